// ----- hw/rtl/nabk_pkg.sv -----
// ----------------------------------------------------------------------------
// nabk_pkg
// Shared types and constants for the nearest anchor by kind search block.
// ----------------------------------------------------------------------------
package nabk_pkg;

  // Default sizing
  localparam int MaxSlotsDef  = 64;
  localparam int CoordBitsDef = 20;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int KIND_W    = 16;
  localparam int ID_W      = 16;
  localparam int HDR_W     = KIND_W + ID_W;
  localparam int ENTRY_W   = 7;
  localparam int OUT_ID_W  = 17;
  localparam int OUT_DST_W = 22;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_HDR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Axis codes for the shared squarer
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Identifier reported when nothing matches
  localparam logic signed [OUT_ID_W-1:0] NO_IDENT = -17'sd1;

  // Slot table write strobes
  typedef struct packed {
    logic hdr;
    logic start_a;
    logic end_a;
  } nabk_wr_t;

  // Tag that travels with one axis term into the squarer
  typedef struct packed {
    logic            vld;
    logic [1:0]      axis;
    logic            elig;
    logic [ID_W-1:0] ident;
  } nabk_tag_t;

  // Tag that travels with a finished squared distance
  typedef struct packed {
    logic            vld;
    logic            elig;
    logic [ID_W-1:0] ident;
  } nabk_res_t;

endpackage

// ----- hw/rtl/nabk_slot_mem.sv -----
// ----------------------------------------------------------------------------
// nabk_slot_mem
// Connector slot table: header, start anchor and end anchor arrays with one
// shared write address and one registered read port.
// ----------------------------------------------------------------------------
module nabk_slot_mem
  import nabk_pkg::*;
#(
  parameter int MAX_SLOTS  = MaxSlotsDef,
  parameter int COORD_BITS = CoordBitsDef,
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int ANC_W     = 1 + 3 * COORD_BITS
) (
  input  logic                      clk,
  input  nabk_wr_t                  wr,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [HDR_W-1:0]          wr_hdr,
  input  logic [ANC_W-1:0]          wr_anchor,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [HDR_W-1:0]          rd_hdr,
  output logic [ANC_W-1:0]          rd_start,
  output logic [ANC_W-1:0]          rd_end
);

  logic [HDR_W-1:0] hdr_mem   [MAX_SLOTS];
  logic [ANC_W-1:0] start_mem [MAX_SLOTS];
  logic [ANC_W-1:0] end_mem   [MAX_SLOTS];

  // Header array
  always_ff @(posedge clk) begin
    if (wr.hdr) begin
      hdr_mem[wr_addr] <= wr_hdr;
    end
    rd_hdr <= hdr_mem[rd_addr];
  end

  // Start anchor array
  always_ff @(posedge clk) begin
    if (wr.start_a) begin
      start_mem[wr_addr] <= wr_anchor;
    end
    rd_start <= start_mem[rd_addr];
  end

  // End anchor array
  always_ff @(posedge clk) begin
    if (wr.end_a) begin
      end_mem[wr_addr] <= wr_anchor;
    end
    rd_end <= end_mem[rd_addr];
  end

endmodule

// ----- hw/rtl/nabk_sq_acc.sv -----
// ----------------------------------------------------------------------------
// nabk_sq_acc
// Shared squarer: one axis difference squared per cycle, summed over x, y, z
// into a squared distance with its slot tag.
// ----------------------------------------------------------------------------
module nabk_sq_acc
  import nabk_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  localparam int DIST_W    = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nabk_tag_t                    tag_in,
  input  logic signed [COORD_BITS-1:0] coord_a,
  input  logic signed [COORD_BITS-1:0] coord_b,
  output logic                         busy,
  output logic [DIST_W-1:0]            sum_sq,
  output nabk_res_t                    dist_tag
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int ACC_W  = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0]      mag;
  logic [PROD_W-1:0]          prod;
  nabk_tag_t                  prod_tag;
  logic [ACC_W-1:0]           acc;

  // Difference and magnitude, fits COORD_BITS bits
  always_comb begin
    diff = {coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b};
    mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
  end

  assign busy = prod_tag.vld;

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_tag <= '0;
    end else begin
      prod_tag <= tag_in;
    end
    prod <= PROD_W'(mag) * PROD_W'(mag);
  end

  // Accumulate stage; third axis closes the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tag <= '0;
    end else begin
      dist_tag.vld <= 1'b0;
      if (prod_tag.vld) begin
        unique case (prod_tag.axis)
          AX_X: acc <= ACC_W'(prod);
          AX_Y: acc <= acc + ACC_W'(prod);
          default: begin
            sum_sq         <= DIST_W'(acc) + DIST_W'(prod);
            dist_tag.vld   <= 1'b1;
            dist_tag.elig  <= prod_tag.elig;
            dist_tag.ident <= prod_tag.ident;
          end
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/nabk_isqrt.sv -----
// ----------------------------------------------------------------------------
// nabk_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nabk_isqrt
  import nabk_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  localparam int DIST_W    = 2 * COORD_BITS + 2,
  localparam int RT_W      = COORD_BITS + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIST_W-1:0] value,
  output logic              done,
  output logic [RT_W-1:0]   root
);

  localparam int ITER   = DIST_W / 2;
  localparam int CNT_W  = $clog2(ITER + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] bit_r;
  logic [DIST_W-1:0] trial;
  logic              ge;

  // One digit step
  always_comb begin
    trial = acc + bit_r;
    ge    = (rem >= trial);
  end

  assign root = acc[RT_W-1:0];

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(ITER);
        rem   <= value;
        acc   <= '0;
        bit_r <= DIST_W'(1) << (DIST_W - 2);
      end else if (busy) begin
        if (ge) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bit_r;
        end else begin
          acc <= acc >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/nearest_anchor_by_kind_search.sv -----
// ----------------------------------------------------------------------------
// nearest_anchor_by_kind_search
// Connector table with a linear nearest-anchor search filtered by kind mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per command.
//   Header, start anchor and end anchor writes give no
//   result. A query scans slots 0 .. entry_count-1 (clamped to MAX_SLOTS)
//   and gives one result on the output channel (out_valid / out_stall):
//   found, nearest_ident (-1 when nothing matches) and distance, the floor
//   square root of the least squared distance in 1/8 units.
//   A query runs the single shared squarer over the x, y and z terms of
//   each slot in turn, then the square root unit retires one result bit per
//   cycle. in_stall stays high while a query runs. The result sits in an
//   output register; loads are accepted while it waits, and a following
//   query runs but holds its result until the register frees. entry_count
//   is written through cfg_write_en / cfg_write_data; the user must write
//   it only while idle, and the block itself does not enforce this.
//   Reset (rst, synchronous) clears entry_count and the handshake state; the
//   slot table is not cleared, so slots must be written before being scanned.
// ----------------------------------------------------------------------------
module nearest_anchor_by_kind_search
  import nabk_pkg::*;
#(
  parameter int MAX_SLOTS  = MaxSlotsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [ENTRY_W-1:0]           cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CMD_W-1:0]             command,
  input  logic [SLOT_W-1:0]            slot,
  input  logic [KIND_W-1:0]            kind_bits,
  input  logic [ID_W-1:0]              connector_ident,
  input  logic                         anchor_valid,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [KIND_W-1:0]            query_mask,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic signed [OUT_ID_W-1:0]   nearest_ident,
  output logic [OUT_DST_W-1:0]         distance
);

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int ANC_W  = 1 + 3 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int RT_W   = COORD_BITS + 1;
  localparam int C2     = 2 * COORD_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                   state;
  logic [ENTRY_W-1:0]           entry_count;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_lim;
  logic [CNT_W-1:0]             rd_addr;
  logic [1:0]                   axis;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic [KIND_W-1:0]            mask;
  logic                         have;
  logic [DIST_W-1:0]            best;
  logic [ID_W-1:0]              best_id;

  logic                         in_accept;
  nabk_wr_t                     wr;
  logic [IDX_W-1:0]             wr_addr;
  logic [IDX_W-1:0]             wrap_tab [SLOT_SPAN];
  logic [HDR_W-1:0]             rd_hdr;
  logic [ANC_W-1:0]             rd_start;
  logic [ANC_W-1:0]             rd_end;
  logic [ANC_W-1:0]             anc;
  logic                         elig;

  nabk_tag_t                    tag_in;
  logic signed [COORD_BITS-1:0] coord_a, coord_b;
  logic                         sq_busy;
  logic [DIST_W-1:0]            sum_sq;
  nabk_res_t                    dist_tag;
  logic                         better;

  logic                         root_start;
  logic                         root_done;
  logic [RT_W-1:0]              root;

  // Handshake
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // Slot index wraps modulo the table depth
  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_wrap
    localparam int WrapIdx = g % MAX_SLOTS;
    assign wrap_tab[g] = IDX_W'(WrapIdx);
  end
  assign wr_addr = wrap_tab[slot];

  // Load strobes
  always_comb begin
    wr.hdr     = in_accept && (command == CMD_HDR);
    wr.start_a = in_accept && (command == CMD_START);
    wr.end_a   = in_accept && (command == CMD_END);
  end

  nabk_slot_mem #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_mem (
    .clk       (clk),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_hdr    ({kind_bits, connector_ident}),
    .wr_anchor ({anchor_valid, coord_x, coord_y, coord_z}),
    .rd_addr   (rd_addr[IDX_W-1:0]),
    .rd_hdr    (rd_hdr),
    .rd_start  (rd_start),
    .rd_end    (rd_end)
  );

  // Clamp of the entry count
  always_comb begin
    if (CMP_W'(entry_count) > CMP_W'(MAX_SLOTS)) begin
      count_lim = CNT_W'(MAX_SLOTS);
    end else begin
      count_lim = CNT_W'(entry_count);
    end
  end

  // Anchor choice and kind filter for the slot on the read port
  always_comb begin
    anc  = rd_start[ANC_W-1] ? rd_start : rd_end;
    elig = (|(rd_hdr[HDR_W-1:ID_W] & mask)) && (rd_start[ANC_W-1] || rd_end[ANC_W-1]);
  end

  // Axis operand select for the shared squarer
  always_comb begin
    unique case (axis)
      AX_X: begin
        coord_a = qx;
        coord_b = anc[ANC_W-2:C2];
      end
      AX_Y: begin
        coord_a = qy;
        coord_b = anc[C2-1:COORD_BITS];
      end
      default: begin
        coord_a = qz;
        coord_b = anc[COORD_BITS-1:0];
      end
    endcase
    tag_in.vld   = (state == S_SCAN);
    tag_in.axis  = axis;
    tag_in.elig  = elig;
    tag_in.ident = rd_hdr[ID_W-1:0];
  end

  nabk_sq_acc #(
    .COORD_BITS (COORD_BITS)
  ) u_sq (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag_in),
    .coord_a  (coord_a),
    .coord_b  (coord_b),
    .busy     (sq_busy),
    .sum_sq   (sum_sq),
    .dist_tag (dist_tag)
  );

  // Strictly smaller wins, so the earliest slot keeps a tie
  assign better = dist_tag.vld && dist_tag.elig && (!have || (sum_sq < best));

  assign root_start = (state == S_DRAIN) && !sq_busy && !dist_tag.vld;

  nabk_isqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best),
    .done  (root_done),
    .root  (root)
  );

  // Sequencer, best tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      have        <= 1'b0;
      axis        <= AX_X;
      rd_addr     <= '0;
      count       <= '0;
    end else begin
      if (cfg_write_en) begin
        entry_count <= cfg_write_data;
      end
      // S_OUT refills the register itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      if (better) begin
        have    <= 1'b1;
        best    <= sum_sq;
        best_id <= dist_tag.ident;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept && (command == CMD_QUERY)) begin
            qx      <= coord_x;
            qy      <= coord_y;
            qz      <= coord_z;
            mask    <= query_mask;
            count   <= count_lim;
            rd_addr <= '0;
            have    <= 1'b0;
            state   <= (count_lim == '0) ? S_DRAIN : S_FETCH;
          end
        end
        S_FETCH: begin
          axis  <= AX_X;
          state <= S_SCAN;
        end
        S_SCAN: begin
          unique case (axis)
            AX_X: axis <= AX_Y;
            AX_Y: begin
              axis    <= AX_Z;
              rd_addr <= rd_addr + CNT_W'(1);
            end
            default: begin
              axis <= AX_X;
              if (rd_addr == count) begin
                state <= S_DRAIN;
              end
            end
          endcase
        end
        S_DRAIN: begin
          if (root_start) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            found         <= have;
            nearest_ident <= have ? $signed({1'b0, best_id}) : NO_IDENT;
            distance      <= have ? OUT_DST_W'(root) : '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
